@@ rtl/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and precedence lookup for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // precedence as an unsigned rank: -1 -> 0, '(' -> 1, +- -> 2, */ -> 3
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_OPEN = 2'd1;
  localparam logic [1:0] RANK_ADD  = 2'd2;
  localparam logic [1:0] RANK_MUL  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef enum logic [1:0] {
    KIND_LETTER,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OPER
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tok;
    logic [1:0] rank;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       eoe;
    logic [1:0] err;
  } res_t;

  function automatic logic [1:0] prec_rank(input logic [7:0] c);
    logic [1:0] r;
    r = RANK_NONE;
    if (c == CH_PLUS || c == CH_MINUS) r = RANK_ADD;
    else if (c == CH_STAR || c == CH_SLASH) r = RANK_MUL;
    else if (c == CH_OPEN) r = RANK_OPEN;
    return r;
  endfunction

endpackage

@@ rtl/infix_to_postfix_converter_core.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter, one infix character in, postfix characters out.
// ----------------------------------------------------------------------------
// Each character is taken from the input queue in the idle state and then
// worked against the stack, which moves one entry per cycle while the result
// queue has room; the final character of an expression then flushes every
// entry left on the stack and writes the end result. A two-entry input queue
// and a two-entry result queue let input and output stall independently. The
// end mark and error code ride on the last character emitted for the final
// character and its flush, or on a bare result with out_valid low if none was.
module infix_to_postfix_converter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] token_i,
  input  logic       last_token_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       out_valid_o,
  output logic       end_of_expr_o,
  output logic [1:0] error_code_o
);
  import itp_pkg::*;

  item_t item;
  logic  item_valid, item_take;
  res_t  res;

  itp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .token_i      (token_i),
    .last_token_i (last_token_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take)
  );

  itp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign out_char_o    = res.ch;
  assign out_valid_o   = res.valid;
  assign end_of_expr_o = res.eoe;
  assign error_code_o  = res.err;

endmodule

@@ rtl/itp_front.sv @@
// ----------------------------------------------------------------------------
// itp_front
// Accepts characters, classifies them and queues them for the stack engine.
// ----------------------------------------------------------------------------
module itp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    token_i,
  input  logic          last_token_i,
  output itp_pkg::item_t item_o,
  output logic          item_valid_o,
  input  logic          item_take_i
);
  import itp_pkg::*;

  item_t      q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      cls;
  logic       wr_en, rd_en;

  always_comb begin
    cls.tok  = token_i;
    cls.last = last_token_i;
    cls.rank = prec_rank(token_i);
    if (token_i >= CH_LO_A && token_i <= CH_LO_Z) cls.kind = KIND_LETTER;
    else if (token_i == CH_OPEN) cls.kind = KIND_OPEN;
    else if (token_i == CH_CLOSE) cls.kind = KIND_CLOSE;
    else cls.kind = KIND_OPER;
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_mem_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) q_mem_q[wr_ptr_q] <= cls;
  end

endmodule

@@ rtl/itp_back.sv @@
// ----------------------------------------------------------------------------
// itp_back
// Stack engine: runs one queued character at a time against the operator
// stack and feeds a two-entry result queue.
// ----------------------------------------------------------------------------
module itp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  itp_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_take_o,
  output logic           empty,
  input  logic           pop,
  output itp_pkg::res_t  res_o
);
  import itp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_FLUSH
  } state_e;

  state_e           state_q, state_d;
  item_t            cur_q, cur_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       top_q, top_d;
  logic [7:0]       nxt_q;
  logic [1:0]       err_q, err_d;
  res_t             pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;

  // stack below the top entry; top lives in top_q, the one under it in nxt_q
  logic [7:0]       stk_mem [STACK_DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic             mem_re;

  // result queue
  res_t             oq_mem_q [2];
  logic             oq_wr_ptr_q, oq_rd_ptr_q;
  logic [1:0]       oq_cnt_q;
  logic             oq_full, oq_wr, oq_rd;
  res_t             oq_wdata;

  logic             has_top, stk_full;
  logic             do_pop, do_push, emit, finish, set_err, end_wr;
  logic [7:0]       push_ch;
  logic [1:0]       err_code;
  res_t             new_res;

  assign has_top  = (count_q != '0);
  assign stk_full = (count_q == CNT_W'(STACK_DEPTH));
  assign oq_full  = (oq_cnt_q == 2'd2);

  // action of this cycle
  always_comb begin
    do_pop   = 1'b0;
    do_push  = 1'b0;
    emit     = 1'b0;
    finish   = 1'b0;
    set_err  = 1'b0;
    end_wr   = 1'b0;
    err_code = ERR_NONE;
    push_ch  = cur_q.tok;
    new_res  = '{ch: top_q, valid: 1'b1, eoe: 1'b0, err: ERR_NONE};
    item_take_o = 1'b0;
    unique case (state_q)
      ST_IDLE: item_take_o = item_valid_i;
      ST_WORK: begin
        if (!oq_full) begin
          unique case (cur_q.kind)
            KIND_LETTER: begin
              emit       = 1'b1;
              new_res.ch = cur_q.tok;
              finish     = 1'b1;
            end
            KIND_OPEN: begin
              do_push = 1'b1;
              finish  = 1'b1;
            end
            KIND_CLOSE: begin
              if (has_top && top_q != CH_OPEN) begin
                do_pop = 1'b1;
                emit   = 1'b1;
              end else if (has_top) begin
                do_pop = 1'b1;
                finish = 1'b1;
              end else begin
                set_err  = 1'b1;
                err_code = ERR_UNMATCHED;
                finish   = 1'b1;
              end
            end
            KIND_OPER: begin
              if (has_top && cur_q.rank <= prec_rank(top_q)) begin
                do_pop = 1'b1;
                emit   = 1'b1;
              end else begin
                do_push = 1'b1;
                finish  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (!oq_full) begin
          if (has_top) begin
            do_pop = 1'b1;
            emit   = 1'b1;
          end else begin
            end_wr = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // push onto a full stack is dropped
    if (do_push && stk_full) begin
      do_push  = 1'b0;
      set_err  = 1'b1;
      err_code = ERR_FULL;
    end
  end

  // stack pointer, top and memory port
  always_comb begin
    count_d   = count_q;
    top_d     = top_q;
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(count_q - CNT_W'(1));
    if (do_push) begin
      mem_we  = has_top;
      top_d   = push_ch;
      count_d = count_q + CNT_W'(1);
    end else if (do_pop) begin
      top_d   = nxt_q;
      count_d = count_q - CNT_W'(1);
    end
    mem_re    = (count_d >= CNT_W'(2));
    mem_raddr = IDX_W'(count_d - CNT_W'(2));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stk_mem[mem_waddr] <= top_q;
    if (mem_re) begin
      if (mem_we && mem_waddr == mem_raddr) nxt_q <= top_q;
      else nxt_q <= stk_mem[mem_raddr];
    end
  end

  // result routing; on the final character results are held back one slot so
  // that the end mark can ride on the last one
  always_comb begin
    oq_wr      = 1'b0;
    oq_wdata   = new_res;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    err_d      = err_q;
    if (set_err && err_q == ERR_NONE) err_d = err_code;
    if (emit) begin
      if (!cur_q.last) begin
        oq_wr = 1'b1;
      end else begin
        oq_wr      = pend_vld_q;
        oq_wdata   = pend_q;
        pend_d     = new_res;
        pend_vld_d = 1'b1;
      end
    end
    if (end_wr) begin
      oq_wr = 1'b1;
      if (pend_vld_q) oq_wdata = '{ch: pend_q.ch, valid: 1'b1, eoe: 1'b1, err: err_q};
      else oq_wdata = '{ch: 8'd0, valid: 1'b0, eoe: 1'b1, err: err_q};
      pend_vld_d = 1'b0;
      err_d      = ERR_NONE;
    end
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          cur_d   = item_i;
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        if (finish) state_d = cur_q.last ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (end_wr) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      err_q      <= ERR_NONE;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      err_q      <= err_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    top_q  <= top_d;
    pend_q <= pend_d;
  end

  // result queue
  assign empty = (oq_cnt_q == 2'd0);
  assign res_o = oq_mem_q[oq_rd_ptr_q];
  assign oq_rd = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_ptr_q <= 1'b0;
      oq_rd_ptr_q <= 1'b0;
      oq_cnt_q    <= 2'd0;
    end else begin
      oq_wr_ptr_q <= oq_wr_ptr_q ^ oq_wr;
      oq_rd_ptr_q <= oq_rd_ptr_q ^ oq_rd;
      oq_cnt_q    <= oq_cnt_q + {1'b0, oq_wr} - {1'b0, oq_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) oq_mem_q[oq_wr_ptr_q] <= oq_wdata;
  end

endmodule

@@ rtl/itp_checker.sv @@
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the converter's result stream.
// ----------------------------------------------------------------------------
module itp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic       out_valid_o,
  input logic       end_of_expr_o,
  input logic [1:0] error_code_o
);
  import itp_pkg::*;

  // a bare result only ever carries the end mark
  a_bare_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_valid_o |-> end_of_expr_o && out_char_o == 8'd0)
    else $error("bare result without end mark");

  a_err_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && error_code_o != ERR_NONE |-> end_of_expr_o)
    else $error("error code outside end result");

  a_err_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> error_code_o != 2'd3)
    else $error("illegal error code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_char_o) && $stable(end_of_expr_o))
    else $error("waiting result changed");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);
